// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the decompressor unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/lz77bd_pkg.sv =====
// ----------------------------------------------------------------------------
// lz77bd_pkg
// Types and constants for the LZ77 (type 0x10) block decompressor.
// ----------------------------------------------------------------------------
package lz77bd_pkg;

    localparam int HIST_DEPTH_DEF = 4096;
    localparam int SIZE_BITS_DEF  = 24;

    localparam int SIZE_W = 24;   // header size field and config register
    localparam int DIST_W = 12;   // distance field of a reference

    localparam logic [7:0]        TYPE_BYTE      = 8'h10;
    localparam logic [4:0]        LEN_BIAS       = 5'd3;
    localparam logic [1:0]        HDR_LAST       = 2'd2;
    localparam logic [3:0]        FLAG_NEEDED    = 4'd8;
    localparam logic [SIZE_W-1:0] MAX_OUT_RESET  = 24'd4096;

    localparam logic [1:0] ST_DATA       = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_BAD_REF    = 2'd2;
    localparam logic [1:0] ST_EARLY_END  = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_REF_LO,
        PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        S_ACCEPT,
        S_LIT,
        S_READ,
        S_COPY,
        S_STAT
    } t_state;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_stream;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_of_run;
        logic       stream_done;
    } t_out_item;

endpackage

// ===== src/lz77bd_ram.sv =====
// ----------------------------------------------------------------------------
// lz77bd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lz77bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lz77_block_decompressor_unit.sv =====
// ----------------------------------------------------------------------------
// lz77_block_decompressor_unit
// Streaming LZ77 type 0x10 decoder, one compressed byte per transaction.
// Header, flag and reference-high bytes are taken in S_ACCEPT; a literal then passes S_LIT.
// A reference then runs S_READ and S_COPY for each copied byte: the history RAM is read, then written.
// A status result passes S_STAT; output back-pressure stretches any of these.
// Reset (i_rst_n low, synchronous) clears control state; history is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lz77_block_decompressor_unit
    import lz77bd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
    parameter int SIZE_BITS     = SIZE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);

    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [1:0]            r_hcnt, n_hcnt;
    logic [SIZE_W-1:0]     r_target, n_target;
    logic [SIZE_BITS-1:0]  r_prod, n_prod;
    logic [7:0]            r_flags, n_flags;
    logic [3:0]            r_fidx, n_fidx;
    logic [7:0]            r_ref_hi, n_ref_hi;
    logic [7:0]            r_lit, n_lit;
    logic                  r_eos, n_eos;
    logic [1:0]            r_status, n_status;
    logic [4:0]            r_len, n_len;
    logic [ADDR_W-1:0]     r_dist, n_dist;
    logic [SIZE_W-1:0]     r_max;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  in_fire;
    logic                  out_free;
    logic                  d_status_en;
    logic [1:0]            d_status;
    logic                  d_lit;
    logic                  d_copy;
    logic [SIZE_W-1:0]     hdr_target;
    logic                  hdr_bad;
    logic [DIST_W:0]       ref_dist;
    logic                  ref_bad;
    logic [SIZE_BITS-1:0]  prod_inc;
    logic                  done;
    logic                  final_copy;
    logic                  ram_we;
    logic [7:0]            ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [7:0]            ram_rdata;

    assign o_in_ready  = (r_state == S_ACCEPT);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign prod_inc   = r_prod + 1'b1;
    assign done       = (SIZE_W'(prod_inc) == r_target);
    assign final_copy = (r_len == 5'd1) || done;

    // Decode one accepted byte against the current parse phase.
    always_comb begin : decode
        d_status_en = 1'b0;
        d_status    = ST_DATA;
        d_lit       = 1'b0;
        d_copy      = 1'b0;
        hdr_target  = r_target | (SIZE_W'(i_in_data.in_byte) << {r_hcnt, 3'b000});
        hdr_bad     = (hdr_target == '0) || (hdr_target > r_max)
                      || ((hdr_target >> SIZE_BITS) != '0);
        ref_dist    = {1'b0, r_ref_hi[3:0], i_in_data.in_byte} + 1'b1;
        ref_bad     = (SIZE_BITS'(ref_dist) > r_prod);
        if (i_in_data.first_of_stream) begin
            if (i_in_data.in_byte != TYPE_BYTE) begin
                d_status_en = 1'b1;
                d_status    = ST_BAD_HEADER;
            end else if (i_in_data.end_of_source) begin
                d_status_en = 1'b1;
                d_status    = ST_EARLY_END;
            end
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hcnt == HDR_LAST && hdr_bad) begin
                        d_status_en = 1'b1;
                        d_status    = ST_BAD_HEADER;
                    end else if (i_in_data.end_of_source) begin
                        d_status_en = 1'b1;
                        d_status    = ST_EARLY_END;
                    end
                end
                PH_BODY: begin
                    if (!r_fidx[3] && !r_flags[7]) begin
                        d_lit = 1'b1;
                    end else if (i_in_data.end_of_source) begin
                        d_status_en = 1'b1;
                        d_status    = ST_EARLY_END;
                    end
                end
                PH_REF_LO: begin
                    if (ref_bad) begin
                        d_status_en = 1'b1;
                        d_status    = ST_BAD_REF;
                    end else begin
                        d_copy = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin : next_state
        n_state = r_state;
        unique case (r_state)
            S_ACCEPT: begin
                if (in_fire) begin
                    if (d_status_en) begin
                        n_state = S_STAT;
                    end else if (d_lit) begin
                        n_state = S_LIT;
                    end else if (d_copy) begin
                        n_state = S_READ;
                    end
                end
            end
            S_LIT: begin
                if (out_free) begin
                    n_state = (!done && r_eos) ? S_STAT : S_ACCEPT;
                end
            end
            S_READ: begin
                n_state = S_COPY;
            end
            S_COPY: begin
                if (out_free) begin
                    if (!final_copy) begin
                        n_state = S_READ;
                    end else begin
                        n_state = (!done && r_eos) ? S_STAT : S_ACCEPT;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_state = S_ACCEPT;
                end
            end
            default: n_state = S_ACCEPT;
        endcase
    end

    always_comb begin : datapath
        n_phase     = r_phase;
        n_hcnt      = r_hcnt;
        n_target    = r_target;
        n_prod      = r_prod;
        n_flags     = r_flags;
        n_fidx      = r_fidx;
        n_ref_hi    = r_ref_hi;
        n_lit       = r_lit;
        n_eos       = r_eos;
        n_status    = r_status;
        n_len       = r_len;
        n_dist      = r_dist;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_wdata   = r_lit;
        unique case (r_state)
            S_ACCEPT: begin
                if (in_fire) begin
                    n_eos    = i_in_data.end_of_source;
                    n_status = d_status;
                    if (i_in_data.first_of_stream) begin
                        n_phase  = PH_HEADER;
                        n_hcnt   = '0;
                        n_target = '0;
                        n_prod   = '0;
                        n_flags  = '0;
                        n_fidx   = FLAG_NEEDED;
                        n_ref_hi = '0;
                    end else begin
                        unique case (r_phase)
                            PH_HEADER: begin
                                n_target = hdr_target;
                                n_hcnt   = r_hcnt + 1'b1;
                                if (r_hcnt == HDR_LAST && !hdr_bad) begin
                                    n_phase = PH_BODY;
                                end
                            end
                            PH_BODY: begin
                                if (r_fidx[3]) begin
                                    n_flags = i_in_data.in_byte;
                                    n_fidx  = '0;
                                end else begin
                                    // consume the flag MSB first
                                    n_flags = {r_flags[6:0], 1'b0};
                                    n_fidx  = r_fidx + 1'b1;
                                    if (r_flags[7]) begin
                                        n_ref_hi = i_in_data.in_byte;
                                        n_phase  = PH_REF_LO;
                                    end else begin
                                        n_lit = i_in_data.in_byte;
                                    end
                                end
                            end
                            PH_REF_LO: begin
                                n_phase = PH_BODY;
                                n_len   = {1'b0, r_ref_hi[7:4]} + LEN_BIAS;
                                n_dist  = ADDR_W'(ref_dist);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_LIT: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_wdata   = r_lit;
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: r_lit, status: ST_DATA,
                                    last_of_run: done || !r_eos, stream_done: done};
                    n_prod      = prod_inc;
                    if (done) begin
                        n_phase = PH_HALT;
                    end else if (r_eos) begin
                        n_status = ST_EARLY_END;
                    end
                end
            end
            S_COPY: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata;
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: ram_rdata, status: ST_DATA,
                                    last_of_run: final_copy && (done || !r_eos),
                                    stream_done: done};
                    n_prod      = prod_inc;
                    n_len       = r_len - 1'b1;
                    if (done) begin
                        n_phase = PH_HALT;
                    end else if (final_copy && r_eos) begin
                        n_status = ST_EARLY_END;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: 8'h00, status: r_status,
                                    last_of_run: 1'b1, stream_done: 1'b0};
                    n_phase     = PH_HALT;
                end
            end
            default: begin
            end
        endcase
    end

    assign ram_re    = (r_state == S_READ);
    assign ram_raddr = r_prod[ADDR_W-1:0] - r_dist;

    lz77bd_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_history (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_prod[ADDR_W-1:0]),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCEPT;
            r_phase     <= PH_IDLE;
            r_hcnt      <= '0;
            r_target    <= '0;
            r_prod      <= '0;
            r_flags     <= '0;
            r_fidx      <= FLAG_NEEDED;
            r_ref_hi    <= '0;
            r_len       <= '0;
            r_status    <= ST_DATA;
            r_out_valid <= 1'b0;
            r_max       <= MAX_OUT_RESET;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_hcnt      <= n_hcnt;
            r_target    <= n_target;
            r_prod      <= n_prod;
            r_flags     <= n_flags;
            r_fidx      <= n_fidx;
            r_ref_hi    <= n_ref_hi;
            r_len       <= n_len;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lit  <= n_lit;
        r_eos  <= n_eos;
        r_dist <= n_dist;
        r_out  <= n_out;
    end

    `ASSERT_CLK(a_copy_len_live, (r_state == S_READ || r_state == S_COPY) |-> (r_len != 5'd0), "copy running with zero length")
    `ASSERT_CLK(a_prod_below_target, (r_phase == PH_BODY || r_phase == PH_REF_LO) |-> (SIZE_W'(r_prod) < r_target), "output count reached size without halt")
    `ASSERT_CLK(a_done_is_last, (o_out_valid && o_out_data.stream_done) |-> (o_out_data.last_of_run && o_out_data.status == ST_DATA), "stream end not last of run")
    `ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_ACCEPT && !r_out_valid), "reset left sequencer busy")

endmodule

// ===== bench/lz77_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz77_decode_checker
// Watches the source, result and max-size channels of the LZ77 decompressor,
// decodes every accepted source byte on its own copy of the decoder state and
// compares each accepted result, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module lz77_decode_checker
    import lz77bd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    t_phase            dec_phase;
    logic [1:0]        hdr_cnt;
    logic [SIZE_W-1:0] size_target;
    logic [SIZE_W-1:0] size_done;
    logic [SIZE_W-1:0] max_size;
    logic [7:0]        flag_reg;
    logic [3:0]        flag_pos;
    logic [7:0]        ref_hi;
    logic [7:0]        hist_mem [0:HIST_DEPTH_DEF-1];

    t_out_item step_out[$];
    t_out_item expected_out[$];
    int        fail_count = 0;
    int        checked    = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                     $time, what, got_v, want_v, checked);
    endtask

    task automatic clear_stream();
        hdr_cnt     = '0;
        size_target = '0;
        size_done   = '0;
        flag_reg    = '0;
        flag_pos    = FLAG_NEEDED;
        ref_hi      = '0;
    endtask

    task automatic record_byte(input logic [7:0] b);
        t_out_item r;
        hist_mem[size_done[11:0]] = b;
        size_done     = size_done + 1'b1;
        r.out_byte    = b;
        r.status      = ST_DATA;
        r.last_of_run = 1'b0;
        r.stream_done = (size_done == size_target);
        step_out.push_back(r);
    endtask

    task automatic record_status(input logic [1:0] code);
        t_out_item r;
        r        = '0;
        r.status = code;
        step_out.push_back(r);
    endtask

    task automatic decode_byte(input t_in_item it);
        logic [1:0]  err_code;
        bit          err_hit;
        bit          live;
        logic [4:0]  run_len;
        logic [12:0] back_dist;
        int unsigned k;
        t_out_item   r;
        err_code = ST_DATA;
        err_hit  = 1'b0;
        live     = 1'b1;
        step_out.delete();
        if (it.first_of_stream) begin
            // restart from any phase
            dec_phase = PH_HEADER;
            clear_stream();
            if (it.in_byte != TYPE_BYTE) begin
                err_hit  = 1'b1;
                err_code = ST_BAD_HEADER;
            end
        end else begin
            case (dec_phase)
                PH_HEADER: begin
                    size_target = size_target | ({16'd0, it.in_byte} << (8 * hdr_cnt));
                    if (hdr_cnt == HDR_LAST) begin
                        if (size_target == '0 || size_target > max_size) begin
                            err_hit  = 1'b1;
                            err_code = ST_BAD_HEADER;
                        end else begin
                            dec_phase = PH_BODY;
                        end
                    end
                    hdr_cnt = hdr_cnt + 1'b1;
                end
                PH_BODY: begin
                    if (flag_pos >= FLAG_NEEDED) begin
                        flag_reg = it.in_byte;
                        flag_pos = '0;
                    end else begin
                        if (flag_reg[3'd7 - flag_pos[2:0]]) begin
                            ref_hi    = it.in_byte;
                            dec_phase = PH_REF_LO;
                        end else begin
                            record_byte(it.in_byte);
                        end
                        flag_pos = flag_pos + 1'b1;
                    end
                end
                PH_REF_LO: begin
                    run_len   = {1'b0, ref_hi[7:4]} + LEN_BIAS;
                    back_dist = {1'b0, ref_hi[3:0], it.in_byte} + 13'd1;
                    dec_phase = PH_BODY;
                    if (back_dist > size_done) begin
                        err_hit  = 1'b1;
                        err_code = ST_BAD_REF;
                    end else begin
                        // stop the copy as soon as the declared size is reached
                        for (k = 0; k < run_len && size_done < size_target; k++)
                            record_byte(hist_mem[12'(size_done - back_dist)]);
                    end
                end
                default: live = 1'b0;
            endcase
        end

        if (live) begin
            if (err_hit) begin
                record_status(err_code);
                dec_phase = PH_HALT;
            end else if ((dec_phase == PH_BODY || dec_phase == PH_REF_LO) &&
                         size_done >= size_target) begin
                dec_phase = PH_HALT;
            end else if (it.end_of_source) begin
                record_status(ST_EARLY_END);
                dec_phase = PH_HALT;
            end
            if (step_out.size() > 0) begin
                r             = step_out.pop_back();
                r.last_of_run = 1'b1;
                step_out.push_back(r);
            end
            while (step_out.size() > 0)
                expected_out.push_back(step_out.pop_front());
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_out.size() == 0) begin
            report_mismatch("result with none expected", got, 0);
            return;
        end
        want = expected_out.pop_front();
        checked++;
        if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        if (got.stream_done !== want.stream_done)
            report_mismatch("stream_done", got.stream_done, want.stream_done);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_phase = PH_IDLE;
            clear_stream();
            max_size = MAX_OUT_RESET;
            expected_out.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                max_size = i_cfg_data;
            if (i_in_valid && i_in_ready)
                decode_byte(i_in_data);
            if (i_out_valid && i_out_ready)
                check_result(i_out_data);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_out.size();
        o_checked    <= checked;
    end

endmodule

// ===== bench/lz77_block_decompressor_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz77_block_decompressor_unit_test
// Drives compressed streams into the LZ77 decompressor: a directed set of
// header, reference and early-end cases, then random well-formed and broken
// streams under several max-size settings and idling modes, including one
// longer stream sent while the results are held off. A checker module predicts
// and compares every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module lz77_block_decompressor_unit_test;
    import lz77bd_pkg::*;

    localparam int                WATCHDOG_LIMIT = 3000;
    localparam int                SETTLE_CYCLES  = 48;
    localparam int                HOLDOFF_CYCLES = 400;
    localparam int unsigned       LONG_SIZE      = 800;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT     = '1;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    t_in_item          in_item    = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    t_out_item         out_item;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data   = '0;

    int fail_count;
    int pending;
    int checked;

    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    bit                holdoff_req   = 1'b0;
    logic              holdoff_on    = 1'b0;
    int                quiet_cycles  = 0;
    logic [SIZE_W-1:0] cur_max       = MAX_OUT_RESET;
    int unsigned       stream_cnt    = 0;
    int unsigned       byte_cnt      = 0;
    t_in_item          src_q[$];

    lz77_block_decompressor_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    lz77_decode_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= !holdoff_on && ($urandom_range(0, 99) >= stall_pct);

    // hold the result channel off for a long stretch on request
    initial begin
        forever begin
            wait (holdoff_req);
            holdoff_req = 1'b0;
            @(posedge clk);
            holdoff_on <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clk);
            holdoff_on <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item src_item(input logic [7:0] b, input logic first,
                                          input logic eos);
        t_in_item it;
        it.in_byte         = b;
        it.first_of_stream = first;
        it.end_of_source   = eos;
        return it;
    endfunction

    task automatic mark_last_eos();
        t_in_item it;
        it               = src_q.pop_back();
        it.end_of_source = 1'b1;
        src_q.push_back(it);
    endtask

    task automatic push_header(input logic [SIZE_W-1:0] size);
        src_q.push_back(src_item(TYPE_BYTE, 1'b1, 1'b0));
        src_q.push_back(src_item(size[7:0], 1'b0, 1'b0));
        src_q.push_back(src_item(size[15:8], 1'b0, 1'b0));
        src_q.push_back(src_item(size[23:16], 1'b0, 1'b0));
    endtask

    // Encode tokens until size bytes are covered; a bad reference ends the body.
    task automatic build_body(input int unsigned size, input int unsigned ref_pct,
                              input bit bad_ref, input int unsigned min_len);
        int unsigned made;
        int unsigned tok;
        int unsigned bad_at;
        int unsigned len;
        int unsigned back_dist;
        int unsigned span;
        int unsigned k;
        bit          is_ref;
        logic [7:0]  flags;
        logic [11:0] code;
        logic [7:0]  grp[$];
        made   = 0;
        tok    = 0;
        bad_at = bad_ref ? $urandom_range(0, 6) : 32'hFFFF_FFFF;
        while (made < size) begin
            flags = 8'h00;
            grp.delete();
            for (k = 0; k < 8; k++) begin
                if (made >= size) begin
                    flags[7 - k] = 1'($urandom_range(0, 1));
                end else begin
                    is_ref = 1'b0;
                    if (tok == bad_at && made < HIST_DEPTH_DEF) begin
                        // reach back past the start of the output
                        is_ref    = 1'b1;
                        len       = $urandom_range(3, 18);
                        back_dist = $urandom_range(made + 1, HIST_DEPTH_DEF);
                    end else if (made > 0 && $urandom_range(0, 99) < ref_pct) begin
                        is_ref    = 1'b1;
                        len       = $urandom_range(min_len, 18);
                        span      = (made < HIST_DEPTH_DEF) ? made : HIST_DEPTH_DEF;
                        back_dist = ($urandom_range(0, 3) == 0) ? span
                                                                : $urandom_range(1, span);
                    end
                    if (is_ref) begin
                        code         = 12'(back_dist - 1);
                        flags[7 - k] = 1'b1;
                        grp.push_back({4'(len - 3), code[11:8]});
                        grp.push_back(code[7:0]);
                        made = (tok == bad_at) ? size : made + len;
                    end else begin
                        grp.push_back(8'($urandom_range(0, 255)));
                        made++;
                    end
                    tok++;
                end
            end
            src_q.push_back(src_item(flags, 1'b0, 1'b0));
            while (grp.size() > 0)
                src_q.push_back(src_item(grp.pop_front(), 1'b0, 1'b0));
        end
    endtask

    task automatic make_stream(output int unsigned counted);
        int unsigned pick;
        int unsigned size;
        int unsigned start;
        int unsigned keep;
        int unsigned cap;
        int unsigned n;
        logic [7:0]  b;
        start = src_q.size();
        pick  = $urandom_range(0, 99);
        cap   = ($urandom_range(0, 9) == 0) ? 300 : 40;
        size  = $urandom_range(1, (cur_max < cap) ? cur_max : cap);
        if (pick >= 94) begin
            n = $urandom_range(1, 4);
            repeat (n)
                src_q.push_back(src_item(8'($urandom_range(0, 255)), 1'b0,
                                         1'($urandom_range(0, 1))));
        end else if (pick >= 88) begin
            b = 8'($urandom_range(0, 255));
            if (b == TYPE_BYTE)
                b = ~b;
            src_q.push_back(src_item(b, 1'b1, 1'($urandom_range(0, 1))));
        end else if (pick >= 82) begin
            if (cur_max == SIZE_LIMIT || $urandom_range(0, 2) == 0)
                size = 0;
            else
                size = cur_max + $urandom_range(1, 50);
            push_header(SIZE_W'(size));
            if ($urandom_range(0, 1))
                mark_last_eos();
        end else begin
            push_header(SIZE_W'(size));
            build_body(size, $urandom_range(0, 85), pick >= 74, 3);
            if (pick < 60) begin
                if ($urandom_range(0, 1))
                    mark_last_eos();
            end else if (pick < 74) begin
                // cut the stream short; with no end mark the next start restarts it
                keep = $urandom_range(1, src_q.size() - start - 1);
                while (src_q.size() > start + keep)
                    void'(src_q.pop_back());
                if (pick < 68)
                    mark_last_eos();
            end
        end
        if (pick < 94)
            stream_cnt++;
        counted = (pick >= 94) ? 0 : src_q.size() - start;
    endtask

    task automatic send_byte(input t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        byte_cnt++;
    endtask

    task automatic send_queued();
        t_in_item it;
        while (src_q.size() > 0) begin
            it = src_q.pop_front();
            send_byte(it);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // let a byte that makes no result finish before touching the register
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max(input logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_max = value;
    endtask

    task automatic run_segment(input logic [SIZE_W-1:0] max_val, input int idle_pct,
                               input int stall, input int unsigned budget);
        int unsigned used;
        int unsigned n;
        settle();
        write_max(max_val);
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
        used = 0;
        while (used < budget) begin
            make_stream(n);
            used += n;
            send_queued();
        end
    endtask

    initial begin : stimulus
        int unsigned k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bad type byte that also ends the source: header error wins
        src_q.push_back(src_item(8'hEF, 1'b1, 1'b1));
        push_header('0);
        push_header(MAX_OUT_RESET + 1'b1);
        // literal then a distance-1 reference; trailing byte after completion is dropped
        push_header(24'd4);
        src_q.push_back(src_item(8'h40, 1'b0, 1'b0));
        src_q.push_back(src_item(8'hFF, 1'b0, 1'b0));
        src_q.push_back(src_item(8'h00, 1'b0, 1'b0));
        src_q.push_back(src_item(8'h00, 1'b0, 1'b1));
        src_q.push_back(src_item(8'h5A, 1'b0, 1'b1));
        // reference before any output, on the last source byte
        push_header(24'd5);
        src_q.push_back(src_item(8'h80, 1'b0, 1'b0));
        src_q.push_back(src_item(8'hF0, 1'b0, 1'b0));
        src_q.push_back(src_item(8'h00, 1'b0, 1'b1));
        // source ends inside the header
        push_header(24'd8);
        mark_last_eos();
        send_queued();

        run_segment(24'd1, 0, 0, 12);
        run_segment(SIZE_LIMIT, 0, 0, 30);

        // largest declared size, cut short
        push_header(SIZE_LIMIT);
        src_q.push_back(src_item(8'h00, 1'b0, 1'b0));
        for (k = 0; k < 3; k++)
            src_q.push_back(src_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
        mark_last_eos();
        stream_cnt++;
        send_queued();

        // long reference-heavy stream; stall the results while it streams in
        push_header(SIZE_W'(LONG_SIZE));
        build_body(LONG_SIZE, 92, 1'b0, 15);
        stream_cnt++;
        holdoff_req = 1'b1;
        send_queued();

        run_segment(24'($urandom_range(16, 600)), 65, 0, 45);
        run_segment(MAX_OUT_RESET, 0, 65, 45);
        run_segment(24'($urandom_range(16, 600)), 27, 27, 45);
        settle();

        $display("Covered %0d streams, %0d source bytes, %0d checked results.",
                 stream_cnt, byte_cnt, checked);
        $display("Max sizes 1, 4096, 16777215 and two random; four idling modes; one hold-off.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
